@@ rtl/lavm_pkg.sv @@
`default_nettype none

package lavm_pkg;

	// Field and datapath widths.
	localparam int COORD_W = 32;
	localparam int DIFF_W = COORD_W + 1;
	localparam int NORM_W = 30;
	localparam int NORM_MSB = NORM_W - 1;
	localparam int SQ_W = 2 * NORM_W + 2;
	localparam int ROOT_W = 64;
	localparam int ROOT_STEPS = 32;
	localparam int LEN_W = 31;
	localparam int POS_W = 6;

	// Default number of fraction bits.
	localparam int FRAC_BITS_DEF = 16;

	// Cycles from the input register of the normalizer to its output register.
	function automatic int norm_lat(input int frac);
		return 8 + ROOT_STEPS + frac;
	endfunction

endpackage

`default_nettype wire

@@ rtl/lavm_norm.sv @@
`default_nettype none

module lavm_norm import lavm_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic signed [DIFF_W-1:0] vec [3],
	output logic out_valid,
	output logic signed [FRAC_BITS+1:0] uvec [3]
);

	localparam int UW = FRAC_BITS + 2;
	localparam int QW = FRAC_BITS + 1;
	localparam int RW = NORM_W + FRAC_BITS + 2;

	// Stage 1: magnitudes and the largest of them.
	logic [DIFF_W-1:0] mag_c [3];
	logic [DIFF_W-1:0] top_c;
	logic [DIFF_W-1:0] mag_s1 [3];
	logic [DIFF_W-1:0] top_s1;
	logic neg_s1 [3];
	logic v_s1;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = vec[i][DIFF_W-1] ? DIFF_W'(-vec[i]) : DIFF_W'(vec[i]);
		end
		top_c = mag_c[0];
		if (mag_c[1] > top_c) top_c = mag_c[1];
		if (mag_c[2] > top_c) top_c = mag_c[2];
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			mag_s1[i] <= mag_c[i];
			neg_s1[i] <= vec[i][DIFF_W-1];
		end
		top_s1 <= top_c;
	end

	// Stage 2: position of the leading one of the largest magnitude.
	logic [POS_W-1:0] pos_c;
	logic [POS_W-1:0] pos_s2;
	logic [DIFF_W-1:0] mag_s2 [3];
	logic neg_s2 [3];
	logic zero_s2;
	logic v_s2;

	always_comb begin
		pos_c = '0;
		for (int b = 0; b < DIFF_W; b++) begin
			if (top_s1[b]) pos_c = POS_W'(b);
		end
	end

	always_ff @(posedge clk) begin
		mag_s2 <= mag_s1;
		neg_s2 <= neg_s1;
		pos_s2 <= pos_c;
		zero_s2 <= (top_s1 == '0);
	end

	// Stage 3: common shift that puts the largest magnitude into [2^29, 2^30).
	logic [DIFF_W-1:0] sh_c [3];
	logic [NORM_W-1:0] nm_s3 [3];
	logic neg_s3 [3];
	logic zero_s3;
	logic v_s3;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (pos_s2 >= POS_W'(NORM_MSB)) begin
				sh_c[i] = mag_s2[i] >> (pos_s2 - POS_W'(NORM_MSB));
			end else begin
				sh_c[i] = mag_s2[i] << (POS_W'(NORM_MSB) - pos_s2);
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			nm_s3[i] <= sh_c[i][NORM_W-1:0];
		end
		neg_s3 <= neg_s2;
		zero_s3 <= zero_s2;
	end

	// Stage 4: squares.
	logic [2*NORM_W-1:0] sqr_s4 [3];
	logic [NORM_W-1:0] nm_s4 [3];
	logic neg_s4 [3];
	logic zero_s4;
	logic v_s4;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sqr_s4[i] <= (2*NORM_W)'(nm_s3[i]) * (2*NORM_W)'(nm_s3[i]);
		end
		nm_s4 <= nm_s3;
		neg_s4 <= neg_s3;
		zero_s4 <= zero_s3;
	end

	// Stage 5 holds the sum of squares; the square root follows, one result bit per stage.
	logic [ROOT_W-1:0] rt_rem [0:ROOT_STEPS];
	logic [ROOT_W-1:0] rt_root [0:ROOT_STEPS];
	logic [NORM_W-1:0] rt_nm [0:ROOT_STEPS][3];
	logic rt_neg [0:ROOT_STEPS][3];
	logic rt_zero [0:ROOT_STEPS];
	logic rt_v [0:ROOT_STEPS];
	logic [ROOT_W-1:0] rt_rem_nx [1:ROOT_STEPS];
	logic [ROOT_W-1:0] rt_root_nx [1:ROOT_STEPS];

	always_comb begin
		logic [ROOT_W-1:0] bit_w;
		logic [ROOT_W-1:0] trial;
		for (int k = 1; k <= ROOT_STEPS; k++) begin
			bit_w = ROOT_W'(1) << (2 * (ROOT_STEPS - k));
			trial = rt_root[k-1] + bit_w;
			if (rt_rem[k-1] >= trial) begin
				rt_rem_nx[k] = rt_rem[k-1] - trial;
				rt_root_nx[k] = (rt_root[k-1] >> 1) + bit_w;
			end else begin
				rt_rem_nx[k] = rt_rem[k-1];
				rt_root_nx[k] = rt_root[k-1] >> 1;
			end
		end
	end

	always_ff @(posedge clk) begin
		rt_rem[0] <= ROOT_W'(SQ_W'(sqr_s4[0]) + SQ_W'(sqr_s4[1]) + SQ_W'(sqr_s4[2]));
		rt_root[0] <= '0;
		rt_nm[0] <= nm_s4;
		rt_neg[0] <= neg_s4;
		rt_zero[0] <= zero_s4;
		for (int k = 1; k <= ROOT_STEPS; k++) begin
			rt_rem[k] <= rt_rem_nx[k];
			rt_root[k] <= rt_root_nx[k];
			rt_nm[k] <= rt_nm[k-1];
			rt_neg[k] <= rt_neg[k-1];
			rt_zero[k] <= rt_zero[k-1];
		end
	end

	// Divider setup: rounded numerator and the length as divisor.
	logic [LEN_W-1:0] len_c;
	logic [RW-1:0] dv_rem [0:QW][3];
	logic [QW-1:0] dv_q [0:QW][3];
	logic [LEN_W-1:0] dv_den [0:QW];
	logic dv_neg [0:QW][3];
	logic dv_zero [0:QW];
	logic dv_v [0:QW];
	logic [RW-1:0] dv_rem_nx [1:QW][3];
	logic [QW-1:0] dv_q_nx [1:QW][3];

	assign len_c = rt_root[ROOT_STEPS][LEN_W-1:0];

	// Restoring division, one quotient bit per stage, most significant first.
	always_comb begin
		logic [RW-1:0] dsh;
		for (int j = 1; j <= QW; j++) begin
			dsh = RW'(dv_den[j-1]) << (QW - j);
			for (int i = 0; i < 3; i++) begin
				dv_q_nx[j][i] = dv_q[j-1][i];
				if (dv_rem[j-1][i] >= dsh) begin
					dv_rem_nx[j][i] = dv_rem[j-1][i] - dsh;
					dv_q_nx[j][i][QW-j] = 1'b1;
				end else begin
					dv_rem_nx[j][i] = dv_rem[j-1][i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			dv_rem[0][i] <= (RW'(rt_nm[ROOT_STEPS][i]) << FRAC_BITS) + RW'(len_c >> 1);
			dv_q[0][i] <= '0;
		end
		dv_den[0] <= len_c;
		dv_neg[0] <= rt_neg[ROOT_STEPS];
		dv_zero[0] <= rt_zero[ROOT_STEPS];
		for (int j = 1; j <= QW; j++) begin
			dv_rem[j] <= dv_rem_nx[j];
			dv_q[j] <= dv_q_nx[j];
			dv_den[j] <= dv_den[j-1];
			dv_neg[j] <= dv_neg[j-1];
			dv_zero[j] <= dv_zero[j-1];
		end
	end

	// Output: apply sign, and a zero vector stays zero.
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (dv_zero[QW]) begin
				uvec[i] <= '0;
			end else if (dv_neg[QW][i]) begin
				uvec[i] <= -$signed(UW'(dv_q[QW][i]));
			end else begin
				uvec[i] <= $signed(UW'(dv_q[QW][i]));
			end
		end
	end

	// Valid bits travel alongside the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			for (int k = 0; k <= ROOT_STEPS; k++) rt_v[k] <= 1'b0;
			for (int j = 0; j <= QW; j++) dv_v[j] <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			rt_v[0] <= v_s4;
			for (int k = 1; k <= ROOT_STEPS; k++) rt_v[k] <= rt_v[k-1];
			dv_v[0] <= rt_v[ROOT_STEPS];
			for (int j = 1; j <= QW; j++) dv_v[j] <= dv_v[j-1];
			out_valid <= dv_v[QW];
		end
	end

endmodule

`default_nettype wire

@@ rtl/look_at_view_matrix_unit.sv @@
// Throughput: one transfer per cycle; busy is never raised.
// The square root (32 stages) and the divider (FRAC_BITS + 1 stages) set the depth.
// Reset is asynchronous and active low; it clears all valid bits, so no done follows.
// The receiver cannot stall: each result is shown for exactly one cycle with done.
`default_nettype none

module look_at_view_matrix_unit import lavm_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic signed [COORD_W-1:0] eye_x,
	input  logic signed [COORD_W-1:0] eye_y,
	input  logic signed [COORD_W-1:0] eye_z,
	input  logic signed [COORD_W-1:0] target_x,
	input  logic signed [COORD_W-1:0] target_y,
	input  logic signed [COORD_W-1:0] target_z,
	input  logic signed [COORD_W-1:0] upvec_x,
	input  logic signed [COORD_W-1:0] upvec_y,
	input  logic signed [COORD_W-1:0] upvec_z,
	output logic done,
	output logic signed [COORD_W-1:0] left_x,
	output logic signed [COORD_W-1:0] left_y,
	output logic signed [COORD_W-1:0] left_z,
	output logic signed [COORD_W-1:0] left_offset,
	output logic signed [COORD_W-1:0] trueup_x,
	output logic signed [COORD_W-1:0] trueup_y,
	output logic signed [COORD_W-1:0] trueup_z,
	output logic signed [COORD_W-1:0] trueup_offset,
	output logic signed [COORD_W-1:0] back_x,
	output logic signed [COORD_W-1:0] back_y,
	output logic signed [COORD_W-1:0] back_z,
	output logic signed [COORD_W-1:0] back_offset
);

	localparam int UW = FRAC_BITS + 2;
	localparam int LW = FRAC_BITS + 3;
	localparam int XW = 2 * LW + 1;
	localparam int PW = LW + COORD_W;
	localparam int DW = PW + 2;
	localparam int SW = DW - FRAC_BITS + 1;
	localparam int LN = norm_lat(FRAC_BITS);
	localparam int LAT = LN + 8;
	localparam logic signed [SW-1:0] SMAX = $signed({{(SW-31){1'b0}}, {31{1'b1}}});
	localparam logic signed [SW-1:0] SMIN = $signed({{(SW-31){1'b1}}, 31'd0});

	// Product rounded half away from zero by the fraction bits.
	function automatic logic signed [LW-1:0] rnd_x(input logic signed [XW-1:0] v);
		logic [XW-1:0] m;
		m = v[XW-1] ? XW'(-v) : XW'(v);
		m = (m + (XW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
		return v[XW-1] ? -$signed(LW'(m)) : $signed(LW'(m));
	endfunction

	// Negated, rounded and saturated dot product.
	function automatic logic signed [COORD_W-1:0] neg_dot(input logic signed [DW-1:0] v);
		logic [DW-1:0] m;
		logic signed [SW-1:0] r;
		m = v[DW-1] ? DW'(-v) : DW'(v);
		m = (m + (DW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
		r = v[DW-1] ? $signed(SW'(m)) : -$signed(SW'(m));
		if (r > SMAX) return SMAX[COORD_W-1:0];
		if (r < SMIN) return SMIN[COORD_W-1:0];
		return r[COORD_W-1:0];
	endfunction

	assign busy = 1'b0;

	// Stage 1: exact differences and register the inputs.
	logic signed [COORD_W-1:0] eye_s1 [3];
	logic signed [DIFF_W-1:0] dir_s1 [3];
	logic signed [DIFF_W-1:0] up_s1 [3];
	logic v_s1;

	always_ff @(posedge clk) begin
		eye_s1[0] <= eye_x;
		eye_s1[1] <= eye_y;
		eye_s1[2] <= eye_z;
		dir_s1[0] <= DIFF_W'(target_x) - DIFF_W'(eye_x);
		dir_s1[1] <= DIFF_W'(target_y) - DIFF_W'(eye_y);
		dir_s1[2] <= DIFF_W'(target_z) - DIFF_W'(eye_z);
		up_s1[0] <= DIFF_W'(upvec_x);
		up_s1[1] <= DIFF_W'(upvec_y);
		up_s1[2] <= DIFF_W'(upvec_z);
	end

	// Normalize forward and up in two parallel units.
	logic signed [UW-1:0] fwd_n [3];
	logic signed [UW-1:0] upn_n [3];
	logic fv_n;
	logic uv_n;

	lavm_norm #(.FRAC_BITS(FRAC_BITS)) u_norm_fwd (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s1), .vec(dir_s1),
		.out_valid(fv_n), .uvec(fwd_n)
	);

	lavm_norm #(.FRAC_BITS(FRAC_BITS)) u_norm_up (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s1), .vec(up_s1),
		.out_valid(uv_n), .uvec(upn_n)
	);

	// Eye delay line matching the normalizer.
	logic signed [COORD_W-1:0] eye_d [1:LN][3];

	always_ff @(posedge clk) begin
		eye_d[1] <= eye_s1;
		for (int k = 2; k <= LN; k++) eye_d[k] <= eye_d[k-1];
	end

	// Stage 2: products for left = forward x up.
	logic signed [2*LW-1:0] pa_s2 [6];
	logic signed [UW-1:0] fwd_s2 [3];
	logic signed [COORD_W-1:0] eye_s2 [3];
	logic v_s2;

	always_ff @(posedge clk) begin
		pa_s2[0] <= LW'(fwd_n[1]) * LW'(upn_n[2]);
		pa_s2[1] <= LW'(fwd_n[2]) * LW'(upn_n[1]);
		pa_s2[2] <= LW'(fwd_n[2]) * LW'(upn_n[0]);
		pa_s2[3] <= LW'(fwd_n[0]) * LW'(upn_n[2]);
		pa_s2[4] <= LW'(fwd_n[0]) * LW'(upn_n[1]);
		pa_s2[5] <= LW'(fwd_n[1]) * LW'(upn_n[0]);
		fwd_s2 <= fwd_n;
		eye_s2 <= eye_d[LN];
	end

	// Stage 3: left vector.
	logic signed [LW-1:0] left_s3 [3];
	logic signed [UW-1:0] fwd_s3 [3];
	logic signed [COORD_W-1:0] eye_s3 [3];
	logic v_s3;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			left_s3[i] <= rnd_x(XW'(pa_s2[2*i]) - XW'(pa_s2[2*i+1]));
		end
		fwd_s3 <= fwd_s2;
		eye_s3 <= eye_s2;
	end

	// Stage 4: products for true up = left x forward.
	logic signed [2*LW-1:0] pb_s4 [6];
	logic signed [LW-1:0] left_s4 [3];
	logic signed [UW-1:0] fwd_s4 [3];
	logic signed [COORD_W-1:0] eye_s4 [3];
	logic v_s4;

	always_ff @(posedge clk) begin
		pb_s4[0] <= left_s3[1] * LW'(fwd_s3[2]);
		pb_s4[1] <= left_s3[2] * LW'(fwd_s3[1]);
		pb_s4[2] <= left_s3[2] * LW'(fwd_s3[0]);
		pb_s4[3] <= left_s3[0] * LW'(fwd_s3[2]);
		pb_s4[4] <= left_s3[0] * LW'(fwd_s3[1]);
		pb_s4[5] <= left_s3[1] * LW'(fwd_s3[0]);
		left_s4 <= left_s3;
		fwd_s4 <= fwd_s3;
		eye_s4 <= eye_s3;
	end

	// Stage 5: true up and back rows.
	logic signed [LW-1:0] rows_s5 [3][3];
	logic signed [COORD_W-1:0] eye_s5 [3];
	logic v_s5;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			rows_s5[0][i] <= left_s4[i];
			rows_s5[1][i] <= rnd_x(XW'(pb_s4[2*i]) - XW'(pb_s4[2*i+1]));
			rows_s5[2][i] <= -LW'(fwd_s4[i]);
		end
		eye_s5 <= eye_s4;
	end

	// Stage 6: row times eye products.
	logic signed [PW-1:0] pd_s6 [3][3];
	logic signed [LW-1:0] rows_s6 [3][3];
	logic v_s6;

	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++) begin
			for (int i = 0; i < 3; i++) begin
				pd_s6[j][i] <= PW'(rows_s5[j][i]) * PW'(eye_s5[i]);
			end
		end
		rows_s6 <= rows_s5;
	end

	// Stage 7: dot product sums.
	logic signed [DW-1:0] dot_s7 [3];
	logic signed [LW-1:0] rows_s7 [3][3];
	logic v_s7;

	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++) begin
			dot_s7[j] <= DW'(pd_s6[j][0]) + DW'(pd_s6[j][1]) + DW'(pd_s6[j][2]);
		end
		rows_s7 <= rows_s6;
	end

	// Output register.
	always_ff @(posedge clk) begin
		left_x <= COORD_W'(rows_s7[0][0]);
		left_y <= COORD_W'(rows_s7[0][1]);
		left_z <= COORD_W'(rows_s7[0][2]);
		left_offset <= neg_dot(dot_s7[0]);
		trueup_x <= COORD_W'(rows_s7[1][0]);
		trueup_y <= COORD_W'(rows_s7[1][1]);
		trueup_z <= COORD_W'(rows_s7[1][2]);
		trueup_offset <= neg_dot(dot_s7[1]);
		back_x <= COORD_W'(rows_s7[2][0]);
		back_y <= COORD_W'(rows_s7[2][1]);
		back_z <= COORD_W'(rows_s7[2][2]);
		back_offset <= neg_dot(dot_s7[2]);
	end

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= fv_n && uv_n;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			done <= v_s7;
		end
	end

	// A result leaves exactly the pipeline depth after its start.
	a_done_lat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("done without a matching start");

	// The two normalizers stay in step.
	a_norm_sync: assert property (@(posedge clk) disable iff (!arst_n)
		fv_n == uv_n)
		else $error("normalizer valid bits out of step");

	// A zero forward vector leaves the whole matrix zero.
	a_zero_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(done && back_x == 0 && back_y == 0 && back_z == 0) |->
		(left_x == 0 && left_y == 0 && left_z == 0 && trueup_x == 0 &&
		 trueup_y == 0 && trueup_z == 0 && left_offset == 0 &&
		 trueup_offset == 0 && back_offset == 0))
		else $error("zero forward gave a nonzero row");

endmodule

`default_nettype wire
